// ===== hw/rtl/soc_pkg.sv =====
// Shared constants, codes and control/status types for the sorted occurrence counter.
package soc_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  // Search bounds carry one extra sign bit so that hi can reach -1.
  localparam int BND_W       = CNT_W + 1;

  localparam int CMD_W = 2;
  localparam int STS_W = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STS_W-1:0] ST_CLEARED   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take the input transaction
    logic pass_start;  // reload the bounds for the right-leaning pass
    logic probe_addr;  // register mid and read the store
    logic probe_cmp;   // compare the read word and narrow the range
    logic pass_right;  // current pass leans right
    logic load_out;    // load the result register
  } soc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_open;  // lo <= hi
  } soc_sts_t;

endpackage

// ===== hw/rtl/soc_ctrl.sv =====
// Controller state machine sequencing commands and the two binary-search passes.
module soc_ctrl import soc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  soc_sts_t         sts,
  output soc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    cmd.pass_right = pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          pass_nxt   = 1'b0;
          state_nxt  = (in_command == CMD_QUERY) ? S_ADDR : S_DONE;
        end
      end
      S_ADDR: begin
        if (sts.range_open) begin
          cmd.probe_addr = 1'b1;
          state_nxt      = S_CMP;
        end else if (!pass_r) begin
          cmd.pass_start = 1'b1;
          pass_nxt       = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = S_ADDR;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/soc_dp.sv =====
// Datapath: element store, fill count, search bounds, comparator and result register.
module soc_dp import soc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CMD_W-1:0]              in_command,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  soc_cmd_t                      cmd,
  output soc_sts_t                      sts,
  output logic [STS_W-1:0]              out_status,
  output logic [CNT_W-1:0]              out_occurrences,
  output logic [ADDR_W-1:0]             out_first_index,
  output logic [ADDR_W-1:0]             out_last_index
);

  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]              fill_r;
  logic [CMD_W-1:0]              cmd_r;
  logic [STS_W-1:0]              stat_r;
  logic signed [VALUE_WIDTH-1:0] key_r;
  logic signed [VALUE_WIDTH-1:0] rd_r;
  logic signed [BND_W-1:0]       lo_r, hi_r;
  logic [ADDR_W-1:0]             mid_r;
  logic [ADDR_W-1:0]             first_r, last_r;
  logic                          found_r;

  logic [BND_W-1:0]        bnd_sum;
  logic [ADDR_W-1:0]       mid;
  logic signed [BND_W-1:0] mid_ext;
  logic signed [BND_W-1:0] fill_last;
  logic                    full;
  logic [CNT_W-1:0]        occ;

  // Both bounds are non-negative while the range is open, so the halved sum is the midpoint.
  assign bnd_sum   = lo_r + hi_r;
  assign mid       = bnd_sum[ADDR_W:1];
  assign mid_ext   = signed'({{(BND_W-ADDR_W){1'b0}}, mid_r});
  assign fill_last = signed'({1'b0, fill_r}) - BND_W'(1);
  assign full      = (fill_r == CNT_W'(CAPACITY));
  assign occ       = CNT_W'(last_r) - CNT_W'(first_r) + CNT_W'(1);

  assign sts.range_open = (lo_r <= hi_r);

  always_ff @(posedge clk) begin
    if (cmd.accept && in_command == CMD_APPEND && !full) begin
      mem[fill_r[ADDR_W-1:0]] <= in_value;
    end
    if (cmd.probe_addr) begin
      rd_r <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.accept) begin
      if (in_command == CMD_APPEND && !full) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (in_command == CMD_CLEAR) begin
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_command;
      key_r   <= in_value;
      lo_r    <= '0;
      hi_r    <= fill_last;
      found_r <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
      case (in_command)
        CMD_APPEND: stat_r <= full ? ST_FULL : ST_APPENDED;
        CMD_CLEAR:  stat_r <= ST_CLEARED;
        default:    stat_r <= ST_NOT_FOUND;
      endcase
    end
    if (cmd.pass_start) begin
      lo_r <= '0;
      hi_r <= fill_last;
    end
    if (cmd.probe_addr) begin
      mid_r <= mid;
    end
    if (cmd.probe_cmp) begin
      if (rd_r == key_r) begin
        if (cmd.pass_right) begin
          last_r <= mid_r;
          lo_r   <= mid_ext + BND_W'(1);
        end else begin
          first_r <= mid_r;
          found_r <= 1'b1;
          hi_r    <= mid_ext - BND_W'(1);
        end
      end else if (key_r > rd_r) begin
        lo_r <= mid_ext + BND_W'(1);
      end else begin
        hi_r <= mid_ext - BND_W'(1);
      end
    end
    if (cmd.load_out) begin
      if (cmd_r == CMD_QUERY && found_r) begin
        out_status      <= ST_FOUND;
        out_occurrences <= occ;
        out_first_index <= first_r;
        out_last_index  <= last_r;
      end else begin
        out_status      <= stat_r;
        out_occurrences <= '0;
        out_first_index <= '0;
        out_last_index  <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/sorted_occurrence_counter_core.sv =====
// Top level of the sorted occurrence counter: controller plus datapath.
// Append, query and clear transactions each give one result. Append and clear
// pass from acceptance through the done state into the output register; a
// query runs a left-leaning and then a right-leaning binary search over the
// filled entries, each probe having an address step with a registered store
// read and then a compare step. The store holds up to 1024 words. A new
// transaction is accepted while an earlier result still waits in the output
// register. Stored words need no clearing: only entries below the fill count
// are ever read.
module sorted_occurrence_counter_core import soc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [CMD_W-1:0]              in_command,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [STS_W-1:0]              out_status,
  output logic [CNT_W-1:0]              out_occurrences,
  output logic [ADDR_W-1:0]             out_first_index,
  output logic [ADDR_W-1:0]             out_last_index
);

  soc_cmd_t cmd;
  soc_sts_t sts;

  soc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  soc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_occurrences (out_occurrences),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index)
  );

endmodule
